/* hdl/stq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  // default sizes
  localparam int ENTRIES_DEF      = 16;
  localparam int HANDLER_BITS_DEF = 8;
  localparam int OCC_BITS_DEF     = $clog2(ENTRIES_DEF + 1);

  // field widths
  localparam int ACT_W  = 2;
  localparam int STAT_W = 3;
  localparam int SEC_W  = 32;
  localparam int USEC_W = 20;
  localparam int DL_W   = SEC_W + USEC_W;

  // request actions
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_EXPIRE = 2'd2
  } act_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    RS_INSERTED  = 3'd0,
    RS_FULL      = 3'd1,
    RS_REMOVED   = 3'd2,
    RS_NOT_FOUND = 3'd3,
    RS_EXPIRED   = 3'd4,
    RS_NONE_DUE  = 3'd5
  } rsp_code_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INS_START,
    OP_INS_STEP,
    OP_INS_PUT,
    OP_REM_START,
    OP_REM_STEP,
    OP_REM_DONE,
    OP_EXP_START,
    OP_EXP_POP,
    OP_REPLY
  } dp_op_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SCAN,
    S_INS_PUT,
    S_REM_SCAN,
    S_REM_DONE,
    S_EXP_POP
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic      take;
    dp_op_t    op;
    rsp_code_t code;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             accepted;
    logic [ACT_W-1:0] act;
    logic             full;
    logic             cnt_zero;
    logic             head_due;
    logic             ins_stop;
    logic             rem_end;
    logic             exp_more;
    logic             out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hdl/stq_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface stq_req_if import stq_pkg::*; #(
  parameter int HANDLER_BITS = HANDLER_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [HANDLER_BITS-1:0] handler_id;
  logic [SEC_W-1:0]        time_sec;
  logic [USEC_W-1:0]       time_usec;

  modport source (output valid, action, handler_id, time_sec, time_usec, input ready);
  modport sink   (input valid, action, handler_id, time_sec, time_usec, output ready);
endinterface

// result channel
interface stq_rsp_if import stq_pkg::*; #(
  parameter int HANDLER_BITS = HANDLER_BITS_DEF,
  parameter int OCC_BITS     = OCC_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [HANDLER_BITS-1:0] expired_handler;
  logic                    last;
  logic                    queue_empty;
  logic [SEC_W-1:0]        earliest_sec;
  logic [USEC_W-1:0]       earliest_usec;
  logic [OCC_BITS-1:0]     occupancy;

  modport source (output valid, status, expired_handler, last, queue_empty,
                  earliest_sec, earliest_usec, occupancy, input ready);
  modport sink   (input valid, status, expired_handler, last, queue_empty,
                  earliest_sec, earliest_usec, occupancy, output ready);
endinterface

`default_nettype wire

/* hdl/stq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module stq_ctrl import stq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sts.accepted) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.act)
          ACT_INSERT: begin
            if (sts.full) begin
              if (sts.out_free) state_next = S_IDLE;
            end else if (sts.cnt_zero) begin
              state_next = S_INS_PUT;
            end else begin
              state_next = S_INS_SCAN;
            end
          end
          ACT_REMOVE: begin
            if (sts.cnt_zero) begin
              if (sts.out_free) state_next = S_IDLE;
            end else begin
              state_next = S_REM_SCAN;
            end
          end
          ACT_EXPIRE: begin
            if (!sts.head_due) begin
              if (sts.out_free) state_next = S_IDLE;
            end else begin
              state_next = S_EXP_POP;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_INS_SCAN: begin
        if (sts.ins_stop) state_next = S_INS_PUT;
      end
      S_INS_PUT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      S_REM_SCAN: begin
        if (sts.rem_end) state_next = S_REM_DONE;
      end
      S_REM_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      S_EXP_POP: begin
        if (sts.out_free && !sts.exp_more) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.take = 1'b0;
    cmd.op   = OP_NONE;
    cmd.code = RS_INSERTED;
    unique case (state)
      // no request is taken while reset is held
      S_IDLE: cmd.take = !rst;
      S_DECODE: begin
        unique case (sts.act)
          ACT_INSERT: begin
            if (sts.full) begin
              if (sts.out_free) begin
                cmd.op   = OP_REPLY;
                cmd.code = RS_FULL;
              end
            end else begin
              cmd.op = OP_INS_START;
            end
          end
          ACT_REMOVE: begin
            if (sts.cnt_zero) begin
              if (sts.out_free) begin
                cmd.op   = OP_REPLY;
                cmd.code = RS_NOT_FOUND;
              end
            end else begin
              cmd.op = OP_REM_START;
            end
          end
          ACT_EXPIRE: begin
            if (!sts.head_due) begin
              if (sts.out_free) begin
                cmd.op   = OP_REPLY;
                cmd.code = RS_NONE_DUE;
              end
            end else begin
              cmd.op = OP_EXP_START;
            end
          end
          default: cmd.op = OP_NONE;
        endcase
      end
      S_INS_SCAN: cmd.op = OP_INS_STEP;
      S_INS_PUT:  cmd.op = sts.out_free ? OP_INS_PUT : OP_NONE;
      S_REM_SCAN: cmd.op = OP_REM_STEP;
      S_REM_DONE: cmd.op = sts.out_free ? OP_REM_DONE : OP_NONE;
      S_EXP_POP:  cmd.op = sts.out_free ? OP_EXP_POP : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/stq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module stq_dp import stq_pkg::*; #(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int HANDLER_BITS = HANDLER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  stq_req_if.sink          req,
  stq_rsp_if.source        rsp,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts
);

  localparam int IW = $clog2(ENTRIES);      // physical slot address
  localparam int LW = IW + 1;               // logical offset, reaches ENTRIES
  localparam int CW = $clog2(ENTRIES + 1);  // timer count
  localparam int EW = DL_W + HANDLER_BITS;  // {deadline, handler}

  // slot store, circular, logical slot 0 at hptr
  logic [EW-1:0] mem [ENTRIES];

  logic [ACT_W-1:0]        req_act;
  logic [HANDLER_BITS-1:0] req_hid;
  logic [DL_W-1:0]         req_dl;
  logic [EW-1:0]           head_q;
  logic [EW-1:0]           rd_q;
  logic [IW-1:0]           hptr;
  logic [CW-1:0]           count;
  logic [LW-1:0]           idx;
  logic [LW-1:0]           pos;
  logic                    found;

  logic                    out_valid;
  rsp_code_t               out_code;
  logic [HANDLER_BITS-1:0] out_hid;
  logic                    out_last;
  logic                    out_empty;
  logic [DL_W-1:0]         out_dl;
  logic [CW-1:0]           out_cnt;

  logic [LW-1:0]   cnt_l;
  logic [EW-1:0]   req_ent;
  logic [DL_W-1:0] rd_dl, head_dl;
  logic            rd_lt_req, req_lt_rd, head_lt_req;
  logic            idx_zero, shift, match, more, rem_end, out_free, accepted;
  logic            we, re;
  logic [LW-1:0]   woff, roff;
  logic [IW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata;
  logic            emit;
  rsp_code_t       e_code;
  logic [HANDLER_BITS-1:0] e_hid;
  logic            e_last;
  logic [CW-1:0]   e_cnt;
  logic [DL_W-1:0] e_dl;

  // logical offset to physical slot, one wrap at most
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                         input logic [LW-1:0] off);
    logic [LW-1:0] sum;
    sum = LW'(base) + off;
    if (sum >= LW'(ENTRIES)) sum = sum - LW'(ENTRIES);
    return sum[IW-1:0];
  endfunction

  // compares and flags
  assign cnt_l       = LW'(count);
  assign req_ent     = {req_dl, req_hid};
  assign rd_dl       = rd_q[EW-1 -: DL_W];
  assign head_dl     = head_q[EW-1 -: DL_W];
  assign rd_lt_req   = rd_dl < req_dl;
  assign req_lt_rd   = req_dl < rd_dl;
  assign head_lt_req = head_dl < req_dl;
  assign idx_zero    = (idx == '0);
  // slot 0 moves only for a strictly earlier timer, others for not-smaller
  assign shift       = idx_zero ? req_lt_rd : !rd_lt_req;
  assign match       = (rd_q[HANDLER_BITS-1:0] == req_hid);
  assign more        = (count > CW'(1)) && rd_lt_req;
  assign rem_end     = (idx == cnt_l - LW'(1));
  assign out_free    = !out_valid || rsp.ready;
  assign accepted    = req.valid && cmd.take;

  assign req.ready = cmd.take;

  assign sts.accepted = accepted;
  assign sts.act      = req_act;
  assign sts.full     = (count == CW'(ENTRIES));
  assign sts.cnt_zero = (count == '0);
  assign sts.head_due = (count != '0) && head_lt_req;
  assign sts.ins_stop = !shift || idx_zero;
  assign sts.rem_end  = rem_end;
  assign sts.exp_more = more;
  assign sts.out_free = out_free;

  // store port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    woff  = '0;
    roff  = '0;
    wdata = rd_q;
    unique case (cmd.op)
      OP_INS_START: begin
        re   = (count != '0);
        roff = cnt_l - LW'(1);
      end
      OP_INS_STEP: begin
        we   = shift;
        woff = idx + LW'(1);
        re   = !idx_zero;
        roff = idx - LW'(1);
      end
      OP_INS_PUT: begin
        we    = 1'b1;
        woff  = pos;
        wdata = req_ent;
      end
      OP_REM_START: begin
        re = 1'b1;
      end
      OP_REM_STEP: begin
        we   = found;
        woff = idx - LW'(1);
        re   = !rem_end;
        roff = idx + LW'(1);
      end
      OP_EXP_START: begin
        re   = (count > CW'(1));
        roff = LW'(1);
      end
      OP_EXP_POP: begin
        re   = more;
        roff = LW'(2);
      end
      default: ;
    endcase
  end

  assign waddr = phys(hptr, woff);
  assign raddr = phys(hptr, roff);

  // slot store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  // result word contents
  always_comb begin
    emit   = 1'b0;
    e_code = cmd.code;
    e_hid  = '0;
    e_last = 1'b1;
    e_cnt  = count;
    e_dl   = head_dl;
    unique case (cmd.op)
      OP_INS_PUT: begin
        emit   = 1'b1;
        e_code = RS_INSERTED;
        e_cnt  = count + CW'(1);
        e_dl   = (pos == '0) ? req_dl : head_dl;
      end
      OP_REM_DONE: begin
        emit   = 1'b1;
        e_code = found ? RS_REMOVED : RS_NOT_FOUND;
        e_cnt  = found ? count - CW'(1) : count;
      end
      OP_EXP_POP: begin
        emit   = 1'b1;
        e_code = RS_EXPIRED;
        e_hid  = head_q[HANDLER_BITS-1:0];
        e_last = !more;
        e_cnt  = count - CW'(1);
        e_dl   = rd_dl;
      end
      OP_REPLY: emit = 1'b1;
      default: ;
    endcase
  end

  // request capture and scan registers
  always_ff @(posedge clk) begin
    if (accepted) begin
      req_act <= req.action;
      req_hid <= req.handler_id;
      req_dl  <= {req.time_sec, req.time_usec};
    end
    unique case (cmd.op)
      OP_INS_START: begin
        idx <= cnt_l - LW'(1);
        pos <= '0;
      end
      OP_INS_STEP: begin
        if (shift && !idx_zero) idx <= idx - LW'(1);
        if (!shift) pos <= idx + LW'(1);
      end
      OP_INS_PUT: begin
        if (pos == '0) head_q <= req_ent;
      end
      OP_REM_START: begin
        idx <= '0;
      end
      OP_REM_STEP: begin
        idx <= idx + LW'(1);
        // entry after a removed head becomes the new head
        if (found && idx == LW'(1)) head_q <= rd_q;
      end
      OP_EXP_POP: begin
        head_q <= rd_q;
      end
      default: ;
    endcase
  end

  // count, head pointer, match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      hptr  <= '0;
      found <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_INS_PUT:   count <= count + CW'(1);
        OP_REM_START: found <= 1'b0;
        OP_REM_STEP: begin
          if (!found && match) found <= 1'b1;
        end
        OP_REM_DONE: begin
          if (found) count <= count - CW'(1);
        end
        OP_EXP_POP: begin
          count <= count - CW'(1);
          hptr  <= phys(hptr, LW'(1));
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_code  <= e_code;
      out_hid   <= e_hid;
      out_last  <= e_last;
      out_empty <= (e_cnt == '0);
      out_dl    <= (e_cnt == '0) ? '0 : e_dl;
      out_cnt   <= e_cnt;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_code;
  assign rsp.expired_handler = out_hid;
  assign rsp.last            = out_last;
  assign rsp.queue_empty     = out_empty;
  assign rsp.earliest_sec    = out_dl[DL_W-1 -: SEC_W];
  assign rsp.earliest_usec   = out_dl[USEC_W-1:0];
  assign rsp.occupancy       = out_cnt;

endmodule

`default_nettype wire

/* hdl/sorted_timer_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  words
// -------  ---  ---------------------------------------------------------
// req      in   action, handler_id, time_sec, time_usec
// rsp      out  status, expired_handler, last, queue_empty, earliest, occupancy
//
// Insert walks backward from the tail, one slot a cycle.
// Remove walks forward, compacting behind the hit.
// Expire pops from the head; the store is circular, so a pop only moves the head.
// The slot memory takes one read and one write a cycle. rsp stalls
// hold the walk at its result step; req is taken while the last result waits in rsp.
// rst clears the count, head pointer and valid, and holds req.ready low; slots need no clearing.

module sorted_timer_queue import stq_pkg::*; #(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int HANDLER_BITS = HANDLER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  stq_req_if.sink    req,
  stq_rsp_if.source  rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  stq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // slot store and result register
  stq_dp #(
    .ENTRIES      (ENTRIES),
    .HANDLER_BITS (HANDLER_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

`default_nettype wire

/* dv/timer_list_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, keeps its own sorted timer list and compares each
// result word with the oldest predicted one.
module timer_list_checker import stq_pkg::*; #(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int HANDLER_BITS = HANDLER_BITS_DEF,
  parameter int OCC_BITS     = OCC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  logic                    req_ready,
  input  logic [ACT_W-1:0]        req_action,
  input  logic [HANDLER_BITS-1:0] req_handler_id,
  input  logic [SEC_W-1:0]        req_time_sec,
  input  logic [USEC_W-1:0]       req_time_usec,
  input  logic                    rsp_valid,
  input  logic                    rsp_ready,
  input  logic [STAT_W-1:0]       rsp_status,
  input  logic [HANDLER_BITS-1:0] rsp_expired_handler,
  input  logic                    rsp_last,
  input  logic                    rsp_queue_empty,
  input  logic [SEC_W-1:0]        rsp_earliest_sec,
  input  logic [USEC_W-1:0]       rsp_earliest_usec,
  input  logic [OCC_BITS-1:0]     rsp_occupancy,
  output int                      error_count,
  output int                      replies_due,
  output int                      replies_seen,
  output int                      full_drops
);

  localparam int REPORT_MAX = 40;

  typedef struct {
    rsp_code_t               status;
    logic [HANDLER_BITS-1:0] handler;
    logic                    last;
    logic                    empty;
    logic [SEC_W-1:0]        sec;
    logic [USEC_W-1:0]       usec;
    logic [OCC_BITS-1:0]     occ;
  } reply_t;

  reply_t                  predicted_replies[$];
  reply_t                  want;

  // mirror of the sorted store, head at slot 0
  logic [SEC_W-1:0]        timer_sec [ENTRIES];
  logic [USEC_W-1:0]       timer_usec[ENTRIES];
  logic [HANDLER_BITS-1:0] timer_hid [ENTRIES];
  int                      timers_held;

  function automatic logic earlier(input logic [SEC_W-1:0] a_sec,
                                   input logic [USEC_W-1:0] a_usec,
                                   input logic [SEC_W-1:0] b_sec,
                                   input logic [USEC_W-1:0] b_usec);
    if (a_sec != b_sec) return a_sec < b_sec;
    return a_usec < b_usec;
  endfunction

  // queue one result word, status fields taken from the list as it is now
  task automatic post_reply(input rsp_code_t code, input logic [HANDLER_BITS-1:0] hid,
                            input logic fin);
    reply_t r;
    r.status  = code;
    r.handler = hid;
    r.last    = fin;
    r.empty   = (timers_held == 0);
    r.sec     = (timers_held == 0) ? '0 : timer_sec[0];
    r.usec    = (timers_held == 0) ? '0 : timer_usec[0];
    r.occ     = OCC_BITS'(timers_held);
    predicted_replies.push_back(r);
    if (code == RS_FULL) full_drops++;
  endtask

  task automatic drop_timer(input int pos);
    int i;
    for (i = pos; i < timers_held - 1; i++) begin
      timer_sec[i]  = timer_sec[i+1];
      timer_usec[i] = timer_usec[i+1];
      timer_hid[i]  = timer_hid[i+1];
    end
    timers_held--;
  endtask

  // advance the mirror by one request word and predict its results
  task automatic update_timer_list(input logic [ACT_W-1:0] act,
                                   input logic [HANDLER_BITS-1:0] hid,
                                   input logic [SEC_W-1:0] ts,
                                   input logic [USEC_W-1:0] tu);
    int                      pos;
    int                      i;
    int                      pops;
    logic [HANDLER_BITS-1:0] popped;
    logic                    more;
    case (act)
      ACT_INSERT: begin
        if (timers_held >= ENTRIES) begin
          post_reply(RS_FULL, '0, 1'b1);
        end else begin
          // head only when strictly earlier; a tie with the head goes behind it, other ties go in front
          if (timers_held == 0 || earlier(ts, tu, timer_sec[0], timer_usec[0])) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < timers_held && earlier(timer_sec[pos], timer_usec[pos], ts, tu))
              pos++;
          end
          for (i = timers_held; i > pos; i--) begin
            timer_sec[i]  = timer_sec[i-1];
            timer_usec[i] = timer_usec[i-1];
            timer_hid[i]  = timer_hid[i-1];
          end
          timer_sec[pos]  = ts;
          timer_usec[pos] = tu;
          timer_hid[pos]  = hid;
          timers_held++;
          post_reply(RS_INSERTED, '0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        pos = 0;
        while (pos < timers_held && timer_hid[pos] != hid) pos++;
        if (pos < timers_held) begin
          drop_timer(pos);
          post_reply(RS_REMOVED, '0, 1'b1);
        end else begin
          post_reply(RS_NOT_FOUND, '0, 1'b1);
        end
      end
      ACT_EXPIRE: begin
        pops = 0;
        while (timers_held > 0 && earlier(timer_sec[0], timer_usec[0], ts, tu)) begin
          popped = timer_hid[0];
          drop_timer(0);
          more = timers_held > 0 && earlier(timer_sec[0], timer_usec[0], ts, tu);
          post_reply(RS_EXPIRED, popped, !more);
          pops++;
        end
        if (pops == 0) post_reply(RS_NONE_DUE, '0, 1'b1);
      end
      default: begin
        // unused action code: no result, list untouched
      end
    endcase
  endtask

  task automatic check_field(input string label, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (exp_val !== got_val) begin
      error_count++;
      if (error_count <= REPORT_MAX)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, label, exp_val, got_val);
    end
  endtask

  // results first, so a word accepted in the same cycle never meets its own request
  always @(posedge clk) begin
    if (rst) begin
      predicted_replies.delete();
      timers_held  = 0;
      error_count  = 0;
      replies_seen = 0;
      full_drops   = 0;
      replies_due  = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("%0t ns: unexpected result word, expected none, actual status %0d",
                     $time, rsp_status);
        end else begin
          want = predicted_replies.pop_front();
          check_field("status", 64'(want.status), 64'(rsp_status));
          check_field("expired_handler", 64'(want.handler), 64'(rsp_expired_handler));
          check_field("last", 64'(want.last), 64'(rsp_last));
          check_field("queue_empty", 64'(want.empty), 64'(rsp_queue_empty));
          check_field("earliest_sec", 64'(want.sec), 64'(rsp_earliest_sec));
          check_field("earliest_usec", 64'(want.usec), 64'(rsp_earliest_usec));
          check_field("occupancy", 64'(want.occ), 64'(rsp_occupancy));
        end
      end
      if (req_valid && req_ready)
        update_timer_list(req_action, req_handler_id, req_time_sec, req_time_usec);
      replies_due = predicted_replies.size();
    end
  end

endmodule

/* dv/sorted_timer_queue_tb.sv */
`timescale 1ns / 1ps

module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int ENTRIES      = ENTRIES_DEF;
  localparam int HANDLER_BITS = HANDLER_BITS_DEF;
  localparam int OCC_BITS     = OCC_BITS_DEF;

  localparam int RANDOM_WORDS  = 310;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 60;
  localparam int STEADY_FROM   = 200;
  localparam int STEADY_TO     = 260;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst;

  stq_req_if #(.HANDLER_BITS(HANDLER_BITS)) req_ch ();
  stq_rsp_if #(.HANDLER_BITS(HANDLER_BITS), .OCC_BITS(OCC_BITS)) rsp_ch ();

  sorted_timer_queue #(
    .ENTRIES      (ENTRIES),
    .HANDLER_BITS (HANDLER_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  int error_count;
  int replies_due;
  int replies_seen;
  int full_drops;

  timer_list_checker #(
    .ENTRIES      (ENTRIES),
    .HANDLER_BITS (HANDLER_BITS),
    .OCC_BITS     (OCC_BITS)
  ) chk (
    .clk                 (clk),
    .rst                 (rst),
    .req_valid           (req_ch.valid),
    .req_ready           (req_ch.ready),
    .req_action          (req_ch.action),
    .req_handler_id      (req_ch.handler_id),
    .req_time_sec        (req_ch.time_sec),
    .req_time_usec       (req_ch.time_usec),
    .rsp_valid           (rsp_ch.valid),
    .rsp_ready           (rsp_ch.ready),
    .rsp_status          (rsp_ch.status),
    .rsp_expired_handler (rsp_ch.expired_handler),
    .rsp_last            (rsp_ch.last),
    .rsp_queue_empty     (rsp_ch.queue_empty),
    .rsp_earliest_sec    (rsp_ch.earliest_sec),
    .rsp_earliest_usec   (rsp_ch.earliest_usec),
    .rsp_occupancy       (rsp_ch.occupancy),
    .error_count         (error_count),
    .replies_due         (replies_due),
    .replies_seen        (replies_seen),
    .full_drops          (full_drops)
  );

  int               words_sent;
  int               n_insert;
  int               n_remove;
  int               n_expire;
  int               n_ignored;
  int               idle_cycles;
  logic             steady;
  logic [SEC_W-1:0] now_sec;
  logic [USEC_W-1:0] now_usec;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one request word, with random gaps unless in the steady stretch
  task automatic send_word(input logic [ACT_W-1:0] act,
                           input logic [HANDLER_BITS-1:0] hid,
                           input logic [SEC_W-1:0] ts,
                           input logic [USEC_W-1:0] tu);
    if (!steady) begin
      while ($urandom_range(0, 99) < 13) begin
        req_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.handler_id <= hid;
    req_ch.time_sec   <= ts;
    req_ch.time_usec  <= tu;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    words_sent++;
    case (act)
      ACT_INSERT: n_insert++;
      ACT_REMOVE: n_remove++;
      ACT_EXPIRE: n_expire++;
      default:    n_ignored++;
    endcase
    @(negedge clk);
  endtask

  // small id pool so removes hit; now and then any id
  function automatic logic [HANDLER_BITS-1:0] pick_handler();
    if ($urandom_range(0, 3) == 0) return HANDLER_BITS'($urandom);
    return HANDLER_BITS'($urandom_range(0, 15));
  endfunction

  // favors a few values so equal deadlines show up; some out-of-range usec
  function automatic logic [USEC_W-1:0] pick_usec();
    case ($urandom_range(0, 15))
      0:       return USEC_W'($urandom_range(1000000, 20'hFFFFF));
      1, 2:    return '0;
      3, 4:    return USEC_W'(999999);
      5:       return USEC_W'(500000);
      default: return USEC_W'($urandom_range(0, 999999));
    endcase
  endfunction

  // mostly timers near a moving "now", with expiries chasing it
  task automatic send_random_word(input logic burst);
    int roll;
    int ins_cut;
    int rem_cut;
    int exp_cut;
    roll    = $urandom_range(0, 99);
    ins_cut = burst ? 85 : 45;
    rem_cut = ins_cut + (burst ? 5 : 20);
    exp_cut = rem_cut + (burst ? 5 : 25);
    if (roll < ins_cut) begin
      send_word(ACT_INSERT, pick_handler(), now_sec + SEC_W'($urandom_range(0, 4)),
                pick_usec());
    end else if (roll < rem_cut) begin
      send_word(ACT_REMOVE, pick_handler(), $urandom, USEC_W'($urandom));
    end else if (roll < exp_cut) begin
      now_sec  = now_sec + SEC_W'($urandom_range(0, 2));
      now_usec = USEC_W'($urandom_range(0, 999999));
      if ($urandom_range(0, 15) == 0)
        send_word(ACT_EXPIRE, pick_handler(), '1, '1);
      else
        send_word(ACT_EXPIRE, pick_handler(), now_sec, now_usec);
    end else if (roll < exp_cut + (100 - exp_cut) / 2) begin
      send_word(ACT_UNUSED, HANDLER_BITS'($urandom), $urandom, USEC_W'($urandom));
    end else begin
      send_word(ACT_W'($urandom_range(0, 2)), HANDLER_BITS'($urandom), $urandom,
                USEC_W'($urandom));
    end
  endtask

  // stimulus and verdict
  initial begin
    int   i;
    int   start_count;
    int   done_count;
    logic burst;
    rst               = 1'b1;
    steady            = 1'b0;
    burst             = 1'b0;
    words_sent        = 0;
    n_insert          = 0;
    n_remove          = 0;
    n_expire          = 0;
    n_ignored         = 0;
    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_INSERT;
    req_ch.handler_id = '0;
    req_ch.time_sec   = '0;
    req_ch.time_usec  = '0;
    now_sec           = $urandom;
    now_usec          = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty store: nothing due, remove miss, unused action
    send_word(ACT_EXPIRE, 8'h00, 32'd0, 20'd0);
    send_word(ACT_REMOVE, 8'h00, 32'd0, 20'd0);
    send_word(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 20'hFFFFF);
    // ordering: tie with head goes behind, earlier goes in front
    send_word(ACT_INSERT, 8'h00, 32'd5, 20'd500);
    send_word(ACT_INSERT, 8'hFF, 32'd5, 20'd500);
    send_word(ACT_INSERT, 8'h11, 32'd3, 20'hFFFFF);
    send_word(ACT_INSERT, 8'h22, 32'hFFFF_FFFF, 20'hFFFFF);
    send_word(ACT_INSERT, 8'h33, 32'd0, 20'd0);
    send_word(ACT_REMOVE, 8'hFF, 32'd0, 20'd0);
    send_word(ACT_REMOVE, 8'h44, 32'd0, 20'd0);
    // strictly earlier only: the entry at 5.000500 stays
    send_word(ACT_EXPIRE, 8'h00, 32'd5, 20'd500);
    // fill to capacity, then one more
    for (i = 0; i < ENTRIES - 2; i++)
      send_word(ACT_INSERT, HANDLER_BITS'(8'h40 + i), SEC_W'(10 + i % 5),
                USEC_W'(i * 1000));
    send_word(ACT_INSERT, 8'h99, 32'd1, 20'd1);
    // pops everything but the entry at the maximum deadline
    send_word(ACT_EXPIRE, 8'h00, 32'hFFFF_FFFF, 20'hFFFFF);
    send_word(ACT_REMOVE, 8'h22, 32'd0, 20'd0);

    // random part
    start_count = n_insert + n_remove + n_expire;
    done_count  = 0;
    while (done_count < RANDOM_WORDS) begin
      if ($urandom_range(0, 29) == 0) burst = ~burst;
      steady = (done_count >= STEADY_FROM && done_count < STEADY_TO);
      send_random_word(burst);
      done_count = n_insert + n_remove + n_expire - start_count;
    end
    steady = 1'b0;
    req_ch.valid <= 1'b0;

    // drain, then a quiet window for stray words
    while (replies_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d request words: %0d insert, %0d remove, %0d expire, %0d unused",
             words_sent, n_insert, n_remove, n_expire, n_ignored);
    $display("%0d result words checked, %0d inserts dropped on a full store, %0d errors",
             replies_seen, full_drops, error_count);
    if (error_count == 0) begin
      $display("sorted_timer_queue verification clean");
    end else begin
      $display("sorted_timer_queue verification failed");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off while requests keep coming
  initial begin
    logic held_off;
    held_off     = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && words_sent >= HOLD_AT) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 13);
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results still expected",
               $time, STALL_LIMIT, replies_due);
      $display("sorted_timer_queue verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
